FILE: sv/dslr_pkg.sv
package dslr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;

    localparam int ADDR_W    = 28;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int WIDTH_W   = 13;
    localparam int SCALE_W   = 4;
    localparam int PASS_W    = 7;

    localparam int PASS_PER_SCALE = 6;
    localparam int QUOT_BITS      = 8;
    localparam int DIV_CNT_W      = 4;
    localparam int MUL_CNT_W      = 3;

    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd1024;
    localparam logic [SCALE_W-1:0] SCALE_RST       = 4'd1;
    localparam logic [COLOR_W-1:0] COLOR_MAX       = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THICK_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS_SCALE = 3'd5;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // multiplier issue slots
    localparam logic [MUL_CNT_W-1:0] MUL_SZ_MIN = 3'd0;
    localparam logic [MUL_CNT_W-1:0] MUL_MAX_SZ = 3'd1;
    localparam logic [MUL_CNT_W-1:0] MUL_DZ_T   = 3'd2;
    localparam logic [MUL_CNT_W-1:0] MUL_RANGE  = 3'd3;
    localparam logic [MUL_CNT_W-1:0] MUL_ROW    = 3'd4;
    localparam logic [MUL_CNT_W-1:0] MUL_DRAIN  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_WRITE
    } state_t;

endpackage

FILE: sv/depth_shaded_line_raster.sv
// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+-----------------------------------------------
// cfg       | in        | cfg_wr_en         | cfg_index, cfg_wr_data
// s_ (item) | in        | s_valid / s_ready | operation, start_x/y/z, end_x/y/z
// m_ (pixel)| out       | m_valid / m_ready | byte_address, red, green, blue, last_pixel
//
// a load transaction, and a tick on an idle or finished segment, are handled in the idle state
// a tick that draws a pixel runs from accept to result through the shared multiplier
// (5 products plus drain), sign/magnitude prep, 2 x 9 restoring steps on the shared
// divider (red, then blue), and the load of the output register
// reset is synchronous on aresetn: config returns to defaults, no segment is loaded
// a pixel waits in the write step while the output register is still held by m_ready
module depth_shaded_line_raster #(
    parameter int COORD_BITS = dslr_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dslr_pkg::DEPTH_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [dslr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [((DEPTH_BITS > dslr_pkg::WIDTH_W) ? DEPTH_BITS
                                                    : dslr_pkg::WIDTH_W)-1:0] cfg_wr_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [COORD_BITS-1:0]                 s_start_x,
    input  logic [COORD_BITS-1:0]                 s_start_y,
    input  logic signed [DEPTH_BITS-1:0]          s_start_z,
    input  logic [COORD_BITS-1:0]                 s_end_x,
    input  logic [COORD_BITS-1:0]                 s_end_y,
    input  logic signed [DEPTH_BITS-1:0]          s_end_z,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dslr_pkg::ADDR_W-1:0]           m_byte_address,
    output logic [dslr_pkg::COLOR_W-1:0]          m_red,
    output logic [dslr_pkg::COLOR_W-1:0]          m_green,
    output logic [dslr_pkg::COLOR_W-1:0]          m_blue,
    output logic                                  m_last_pixel
);

    import dslr_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = DEPTH_BITS;
    localparam int AW    = (DW > WIDTH_W) ? DW + 1 : WIDTH_W + 1;
    localparam int BW    = CW + 2;
    localparam int PW    = AW + BW;
    localparam int SUM_W = PW + 1;
    localparam int NUM_W = SUM_W + COLOR_W;
    localparam int DIV_W = NUM_W + QUOT_BITS;
    localparam int ERR_W = CW + 4;

    // configuration
    logic [WIDTH_W-1:0]   image_width_reg;
    logic signed [DW-1:0] depth_max_reg;
    logic signed [DW-1:0] depth_min_reg;
    logic [COLOR_W-1:0]   green_level_reg;
    logic                 thick_enable_reg;
    logic [SCALE_W-1:0]   thickness_scale_reg;

    // segment and stepping state
    state_t               state_reg, state_next;
    logic [CW-1:0]        sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] sz_reg, ez_reg;
    logic [CW-1:0]        dx_reg, dy_reg;
    logic                 y_major_reg;
    logic                 active_reg;
    logic [PASS_W-1:0]    pass_index_reg;
    logic [CW-1:0]        cur_x_reg, cur_y_reg;
    logic signed [ERR_W-1:0] err_reg;

    // shared multiplier and accumulators
    logic [CW-1:0]           span_reg, t_reg;
    logic [MUL_CNT_W-1:0]    mul_cnt_reg;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [PW-1:0]    prod_next, prod_reg;
    logic signed [SUM_W-1:0] r_acc_reg, b_acc_reg, den_acc_reg;
    logic [ADDR_W-1:0]       addr_sum, addr_reg;
    logic [CW:0]             row;

    // shared divider
    logic signed [NUM_W-1:0] num_r, num_b, den_ext;
    logic [NUM_W-1:0]        num_r_mag, num_b_mag, den_mag;
    logic [NUM_W-1:0]        num_b_mag_reg;
    logic [NUM_W-1:0]        den_mag_reg;
    logic                    r_force_reg, b_force_reg;
    logic [DIV_W-1:0]        rem_reg, dsh_reg, rem_sub;
    logic                    div_ge, div_done, div_force;
    logic [COLOR_W-1:0]      q_reg, q_step, div_byte, blue_byte;
    logic                    sat_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic                    div_sel_reg;
    logic [COLOR_W-1:0]      red_reg, blue_reg;

    // output register
    logic                 m_valid_reg;
    logic [ADDR_W-1:0]    m_byte_address_reg;
    logic [COLOR_W-1:0]   m_red_reg, m_green_reg, m_blue_reg;
    logic                 m_last_reg;

    // misc combinational
    logic                 s_accept, out_free;
    logic [PASS_W:0]      passes;
    logic                 pass_done, pass_last;
    logic signed [CW:0]   ld_dx, ld_dy;
    logic signed [ERR_W-1:0] ld_dx_e, ld_dy_e, ld_err;
    logic signed [ERR_W-1:0] rs_dx, rs_dy, rs_err;
    logic [CW-1:0]        tk_span, tk_t;
    logic                 adv, more;
    logic signed [ERR_W-1:0] err_n;
    logic signed [CW+1:0] cx, cy, nx, ny, ex_s, ey_s;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign passes    = thick_enable_reg
                     ? (PASS_W+1)'(PASS_PER_SCALE * int'(thickness_scale_reg))
                     : (PASS_W+1)'(1);
    assign pass_done = {1'b0, pass_index_reg} >= passes;
    assign pass_last = ({1'b0, pass_index_reg} + (PASS_W+1)'(1)) >= passes;

    // load: spans and first decision value
    always_comb begin
        ld_dx   = $signed({1'b0, s_start_x}) - $signed({1'b0, s_end_x});
        ld_dy   = $signed({1'b0, s_end_y}) - $signed({1'b0, s_start_y});
        ld_dx_e = ERR_W'(ld_dx);
        ld_dy_e = ERR_W'(ld_dy);
        ld_err  = (ld_dy > ld_dx) ? (ld_dx_e <<< 1) - ld_dy_e : (ld_dy_e <<< 1) - ld_dx_e;
    end

    // restart of a pass from the stored spans
    always_comb begin
        rs_dx  = ERR_W'({1'b0, dx_reg});
        rs_dy  = ERR_W'({1'b0, dy_reg});
        rs_err = y_major_reg ? (rs_dx <<< 1) - rs_dy : (rs_dy <<< 1) - rs_dx;
    end

    // major span and distance walked, a single point counts as span one at distance zero
    always_comb begin
        tk_span = y_major_reg ? dy_reg : dx_reg;
        tk_t    = y_major_reg ? cur_y_reg - sy_reg : sx_reg - cur_x_reg;
        if (tk_span == '0) begin
            tk_span = CW'(1);
            tk_t    = '0;
        end
    end

    // multiplier operand select
    assign row = (CW+1)'(cur_y_reg) + (CW+1)'(pass_index_reg);

    always_comb begin
        case (mul_cnt_reg)
            MUL_SZ_MIN: begin
                mul_a = AW'(sz_reg) - AW'(depth_min_reg);
                mul_b = BW'(span_reg);
            end
            MUL_MAX_SZ: begin
                mul_a = AW'(depth_max_reg) - AW'(sz_reg);
                mul_b = BW'(span_reg);
            end
            MUL_DZ_T: begin
                mul_a = AW'(ez_reg) - AW'(sz_reg);
                mul_b = BW'(t_reg);
            end
            MUL_RANGE: begin
                mul_a = AW'(depth_max_reg) - AW'(depth_min_reg);
                mul_b = BW'(span_reg);
            end
            MUL_ROW: begin
                mul_a = AW'(image_width_reg);
                mul_b = BW'(row);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
        addr_sum  = ADDR_W'(prod_reg) + ADDR_W'(cur_x_reg);
    end

    // numerators times 255, signs and magnitudes
    always_comb begin
        num_r     = (NUM_W'(r_acc_reg) <<< COLOR_W) - NUM_W'(r_acc_reg);
        num_b     = (NUM_W'(b_acc_reg) <<< COLOR_W) - NUM_W'(b_acc_reg);
        den_ext   = NUM_W'(den_acc_reg);
        num_r_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
        num_b_mag = num_b[NUM_W-1] ? NUM_W'(-num_b) : NUM_W'(num_b);
        den_mag   = den_ext[NUM_W-1] ? NUM_W'(-den_ext) : NUM_W'(den_ext);
    end

    // restoring divide step, first step only detects a quotient above 255
    always_comb begin
        div_ge    = rem_reg >= dsh_reg;
        rem_sub   = rem_reg - dsh_reg;
        q_step    = {q_reg[COLOR_W-2:0], div_ge};
        div_done  = div_cnt_reg == DIV_CNT_W'(QUOT_BITS);
        div_force = div_sel_reg ? b_force_reg : r_force_reg;
        div_byte  = div_force ? '0 : (sat_reg ? COLOR_MAX : q_step);
        blue_byte = (depth_max_reg == '0 && depth_min_reg == '0) ? COLOR_MAX : div_byte;
    end

    // bresenham advance
    always_comb begin
        adv  = !err_reg[ERR_W-1];
        cx   = (CW+2)'(cur_x_reg);
        cy   = (CW+2)'(cur_y_reg);
        ex_s = (CW+2)'(ex_reg);
        ey_s = (CW+2)'(ey_reg);
        if (y_major_reg) begin
            err_n = err_reg + (rs_dx <<< 1) - (adv ? (rs_dy <<< 1) : ERR_W'(0));
            nx    = cx - (adv ? (CW+2)'(1) : (CW+2)'(0));
            ny    = cy + (CW+2)'(1);
        end else begin
            err_n = err_reg + (rs_dy <<< 1) - (adv ? (rs_dx <<< 1) : ERR_W'(0));
            nx    = cx - (CW+2)'(1);
            ny    = cy + (adv ? (CW+2)'(1) : (CW+2)'(0));
        end
        more = (nx >= ex_s) && (ny <= ey_s);
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_accept && s_operation == OP_TICK && active_reg && !pass_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_cnt_reg == MUL_DRAIN) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done && div_sel_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= IMAGE_WIDTH_RST;
            depth_max_reg       <= '0;
            depth_min_reg       <= '0;
            green_level_reg     <= '0;
            thick_enable_reg    <= 1'b0;
            thickness_scale_reg <= SCALE_RST;
            active_reg          <= 1'b0;
            pass_index_reg      <= '0;
            mul_cnt_reg         <= '0;
            div_cnt_reg         <= '0;
            div_sel_reg         <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:     image_width_reg     <= cfg_wr_data[WIDTH_W-1:0];
                    CFG_DEPTH_MAX:       depth_max_reg       <= cfg_wr_data[DW-1:0];
                    CFG_DEPTH_MIN:       depth_min_reg       <= cfg_wr_data[DW-1:0];
                    CFG_GREEN_LEVEL:     green_level_reg     <= cfg_wr_data[COLOR_W-1:0];
                    CFG_THICK_ENABLE:    thick_enable_reg    <= cfg_wr_data[0];
                    CFG_THICKNESS_SCALE: thickness_scale_reg <= cfg_wr_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    mul_cnt_reg <= '0;
                    if (s_accept) begin
                        if (s_operation == OP_LOAD) begin
                            active_reg     <= !ld_dx[CW] && !ld_dy[CW];
                            pass_index_reg <= '0;
                        end else if (active_reg && pass_done) begin
                            active_reg <= 1'b0;
                        end
                    end
                end
                ST_MUL: begin
                    mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
                end
                ST_PREP: begin
                    div_cnt_reg <= '0;
                    div_sel_reg <= 1'b0;
                end
                ST_DIV: begin
                    if (div_done) begin
                        div_cnt_reg <= '0;
                        div_sel_reg <= 1'b1;
                    end else begin
                        div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    end
                end
                ST_WRITE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (!more) begin
                            if (pass_last) begin
                                active_reg <= 1'b0;
                            end else begin
                                pass_index_reg <= pass_index_reg + PASS_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_operation == OP_LOAD) begin
                    sx_reg      <= s_start_x;
                    sy_reg      <= s_start_y;
                    sz_reg      <= s_start_z;
                    ex_reg      <= s_end_x;
                    ey_reg      <= s_end_y;
                    ez_reg      <= s_end_z;
                    dx_reg      <= ld_dx[CW-1:0];
                    dy_reg      <= ld_dy[CW-1:0];
                    y_major_reg <= ld_dy > ld_dx;
                    cur_x_reg   <= s_start_x;
                    cur_y_reg   <= s_start_y;
                    err_reg     <= ld_err;
                end
                span_reg <= tk_span;
                t_reg    <= tk_t;
            end
            ST_MUL: begin
                prod_reg <= prod_next;
                // each slot takes the registered product of the slot before it
                case (mul_cnt_reg)
                    MUL_MAX_SZ: r_acc_reg <= SUM_W'(prod_reg);
                    MUL_DZ_T:   b_acc_reg <= SUM_W'(prod_reg);
                    MUL_RANGE: begin
                        r_acc_reg <= r_acc_reg + SUM_W'(prod_reg);
                        b_acc_reg <= b_acc_reg - SUM_W'(prod_reg);
                    end
                    MUL_ROW:    den_acc_reg <= SUM_W'(prod_reg);
                    MUL_DRAIN:  addr_reg <= {addr_sum[ADDR_W-3:0], 2'b00};
                    default: ;
                endcase
            end
            ST_PREP: begin
                num_b_mag_reg <= num_b_mag;
                den_mag_reg   <= den_mag;
                // opposite signs truncate to zero or below, zero divisor gives zero
                r_force_reg   <= (den_acc_reg == '0) || (num_r[NUM_W-1] != den_ext[NUM_W-1]);
                b_force_reg   <= (den_acc_reg == '0) || (num_b[NUM_W-1] != den_ext[NUM_W-1]);
                rem_reg       <= DIV_W'(num_r_mag);
                dsh_reg       <= {den_mag, {QUOT_BITS{1'b0}}};
                q_reg         <= '0;
                sat_reg       <= 1'b0;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (div_sel_reg) begin
                        blue_reg <= blue_byte;
                    end else begin
                        red_reg <= div_byte;
                        rem_reg <= DIV_W'(num_b_mag_reg);
                        dsh_reg <= {den_mag_reg, {QUOT_BITS{1'b0}}};
                        q_reg   <= '0;
                        sat_reg <= 1'b0;
                    end
                end else begin
                    if (div_cnt_reg == '0) begin
                        sat_reg <= div_ge;
                    end else begin
                        q_reg <= q_step;
                        if (div_ge) begin
                            rem_reg <= rem_sub;
                        end
                    end
                    dsh_reg <= dsh_reg >> 1;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    m_byte_address_reg <= addr_reg;
                    m_red_reg          <= red_reg;
                    m_green_reg        <= green_level_reg;
                    m_blue_reg         <= blue_reg;
                    m_last_reg         <= !more && pass_last;
                    if (more) begin
                        cur_x_reg <= nx[CW-1:0];
                        cur_y_reg <= ny[CW-1:0];
                        err_reg   <= err_n;
                    end else if (!pass_last) begin
                        cur_x_reg <= sx_reg;
                        cur_y_reg <= sy_reg;
                        err_reg   <= rs_err;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_address = m_byte_address_reg;
    assign m_red          = m_red_reg;
    assign m_green        = m_green_reg;
    assign m_blue         = m_blue_reg;
    assign m_last_pixel   = m_last_reg;

    a_load_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_LOAD |=> state_reg == ST_IDLE)
        else $error("load transaction started a pixel computation");

    a_write_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRITE && (!m_valid_reg || m_ready) |=> m_valid_reg)
        else $error("finished pixel did not reach the output register");

    a_div_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_cnt_reg <= DIV_CNT_W'(QUOT_BITS))
        else $error("divider step count ran past the quotient width");

endmodule
